>>> rtl/png_scanline_unfilter_defines.svh
// Assertion macros shared by the unfilter RTL.
// PSU_ASSERT checks under reset gating; PSU_ASSERT_ALWAYS checks at every edge.
`ifndef PNG_SCANLINE_UNFILTER_DEFINES_SVH
`define PNG_SCANLINE_UNFILTER_DEFINES_SVH

`ifndef SYNTHESIS
`define PSU_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("png_scanline_unfilter assertion failed");
`define PSU_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("png_scanline_unfilter assertion failed");
`else
`define PSU_ASSERT(lbl, clk, rst_n, prop)
`define PSU_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

>>> rtl/png_unf_pkg.sv
`timescale 1ns / 1ps

package png_unf_pkg;

    // Row filter codes; FILT_BAD marks any type byte above Paeth.
    typedef enum logic [2:0] {
        FILT_NONE  = 3'd0,
        FILT_SUB   = 3'd1,
        FILT_UP    = 3'd2,
        FILT_AVG   = 3'd3,
        FILT_PAETH = 3'd4,
        FILT_BAD   = 3'd5
    } filt_t;

    // Configuration register indexes.
    localparam logic CFG_BPP = 1'b0;
    localparam logic CFG_BPR = 1'b1;

    localparam int unsigned CFG_DATA_W = 13;
    localparam logic [3:0]  BPP_RESET  = 4'd1;
    localparam logic [12:0] BPR_RESET  = 13'd320;

    // Operands of one byte reconstruction.
    typedef struct packed {
        filt_t      filt;
        logic [7:0] raw;
        logic [7:0] left;
        logic [7:0] up;
        logic [7:0] upleft;
    } pred_in_t;

endpackage

>>> rtl/png_scanline_unfilter.sv
`timescale 1ns / 1ps
// PNG scanline unfilter: takes the inflated byte stream of an image, one byte
// per transfer, and returns the reconstructed row bytes. Every row opens with
// a filter-type byte (None, Sub, Up, Average, Paeth) that yields no output;
// the next bytes_per_row bytes each yield one output byte, with m_tlast on the
// last byte of the row. Mark the first byte of an image with s_tuser: it
// restarts the row count and makes the row above read as zero. A filter type
// above 4 passes the row's bytes unchanged and flags each of them in m_tuser.
// Throughput is one byte per clock: a transfer is accepted every cycle the
// output side takes data. Each byte passes column control and the line-store
// read, then the predictor and the output register. The previous row lives
// in a MAX_ROW_BYTES x 8 line store with one write and one registered read
// port; it needs no clearing pass. Write the configuration registers only
// while the block is idle; a bytes_per_pixel of 0 acts as 1 and values
// above MAX_PIXEL_BYTES saturate, and likewise bytes_per_row against 1 and
// MAX_ROW_BYTES.

`include "png_scanline_unfilter_defines.svh"

module png_scanline_unfilter
    import png_unf_pkg::*;
#(
    parameter int unsigned MAX_ROW_BYTES   = 4096,
    parameter int unsigned MAX_PIXEL_BYTES = 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration write channel
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic                  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [7:0] filtered_byte
    input  logic [0:0]            s_tuser,   // [0] start_of_image
    // output stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [7:0]            m_tdata,   // [7:0] pixel_byte
    output logic                  m_tlast,   // row_end
    output logic [0:0]            m_tuser    // [0] bad_filter
);

    localparam int unsigned CNT_W  = $clog2(MAX_ROW_BYTES + 1);
    localparam int unsigned ADDR_W = $clog2(MAX_ROW_BYTES);
    localparam int unsigned LEN_W  = (CNT_W > CFG_DATA_W) ? CNT_W : CFG_DATA_W;
    localparam int unsigned PIX_W  = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_ROW_BYTES);
    localparam logic [3:0]       BPP_MAX = 4'(MAX_PIXEL_BYTES);

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [3:0]            bpp_reg;
    logic [CFG_DATA_W-1:0] bpr_reg;
    logic [3:0]            bpp_eff;
    logic [LEN_W-1:0]      bpr_wide;
    logic [LEN_W-1:0]      len_eff;
    logic [PIX_W-1:0]      win_sel;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bpp_reg <= BPP_RESET;
            bpr_reg <= BPR_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_BPP: bpp_reg <= cfg_data[3:0];
                CFG_BPR: bpr_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Clamp both registers into their working ranges.
    always_comb begin
        if (bpp_reg == 4'd0) begin
            bpp_eff = 4'd1;
        end else if (bpp_reg > BPP_MAX) begin
            bpp_eff = BPP_MAX;
        end else begin
            bpp_eff = bpp_reg;
        end
    end

    assign win_sel  = PIX_W'(bpp_eff - 4'd1);
    assign bpr_wide = LEN_W'(bpr_reg);

    always_comb begin
        if (bpr_wide == '0) begin
            len_eff = LEN_W'(1);
        end else if (bpr_wide > LEN_MAX) begin
            len_eff = LEN_MAX;
        end else begin
            len_eff = bpr_wide;
        end
    end

    // ---------------------------------------------------------------
    // Stage 0: column control, line-store read
    // ---------------------------------------------------------------
    logic [CNT_W-1:0]  cc_reg,    cc_next;
    filt_t             filt_reg,  filt_next;
    logic              first_reg, first_next;

    logic              s_fire;
    logic              sof;
    logic [CNT_W-1:0]  cc_cur;
    logic              first_cur;
    logic              is_data;
    logic              row_last;
    logic [ADDR_W-1:0] col_x;

    assign s_fire    = s_tvalid && s_tready;
    assign sof       = s_tuser[0];
    assign cc_cur    = sof ? '0 : cc_reg;
    assign first_cur = sof ? 1'b1 : first_reg;
    assign is_data   = (cc_cur != '0);
    assign col_x     = ADDR_W'(cc_cur - CNT_W'(1));
    assign row_last  = (LEN_W'(cc_cur) >= len_eff);

    always_comb begin
        cc_next    = cc_reg;
        filt_next  = filt_reg;
        first_next = first_reg;
        if (s_fire) begin
            first_next = first_cur;
            if (!is_data) begin
                // filter-type byte: latch the row's filter and open the row
                filt_next = (s_tdata > 8'd4) ? FILT_BAD : filt_t'(s_tdata[2:0]);
                cc_next   = CNT_W'(1);
            end else if (row_last) begin
                cc_next    = '0;
                first_next = 1'b0;
            end else begin
                cc_next = cc_cur + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cc_reg    <= '0;
            filt_reg  <= FILT_NONE;
            first_reg <= 1'b1;
        end else begin
            cc_reg    <= cc_next;
            filt_reg  <= filt_next;
            first_reg <= first_next;
        end
    end

    // ---------------------------------------------------------------
    // Stage 1: prediction and window update
    // ---------------------------------------------------------------
    logic              s1_valid_reg, s1_valid_next;
    logic              s1_data_reg;
    logic [7:0]        s1_byte_reg;
    filt_t             s1_filt_reg;
    logic [ADDR_W-1:0] s1_x_reg;
    logic              s1_last_reg;
    logic              s1_first_reg;

    logic              s1_fire;
    logic              out_free;
    logic [7:0]        up_byte;
    logic [7:0]        ls_rd_data;
    logic [7:0]        recon;
    logic              recon_bad;
    pred_in_t          pred_op;

    logic [7:0] left_reg [MAX_PIXEL_BYTES];
    logic [7:0] upl_reg  [MAX_PIXEL_BYTES];

    logic       m_valid_reg, m_valid_next;
    logic [7:0] m_pix_reg;
    logic       m_last_reg;
    logic       m_bad_reg;

    assign out_free = !m_valid_reg || m_tready;
    // A filter token leaves no output, so it never waits on the output side.
    assign s1_fire  = s1_valid_reg && (!s1_data_reg || out_free);
    assign s_tready = !s1_valid_reg || s1_fire;

    assign s1_valid_next = s_fire ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            s1_data_reg  <= is_data;
            s1_byte_reg  <= s_tdata;
            s1_filt_reg  <= filt_reg;
            s1_x_reg     <= col_x;
            s1_last_reg  <= row_last;
            s1_first_reg <= first_cur;
        end
    end

    png_unf_line_store #(
        .DEPTH  (MAX_ROW_BYTES),
        .ADDR_W (ADDR_W)
    ) u_line_store (
        .aclk    (aclk),
        .rd_en   (s_fire && is_data),
        .rd_addr (col_x),
        .rd_data (ls_rd_data),
        .wr_en   (s1_fire && s1_data_reg),
        .wr_addr (s1_x_reg),
        .wr_data (recon)
    );

    // The row above reads as zero on the first row of an image.
    assign up_byte = s1_first_reg ? 8'd0 : ls_rd_data;

    assign pred_op.filt   = s1_filt_reg;
    assign pred_op.raw    = s1_byte_reg;
    assign pred_op.left   = left_reg[win_sel];
    assign pred_op.up     = up_byte;
    assign pred_op.upleft = upl_reg[win_sel];

    png_unf_predict u_predict (
        .op     (pred_op),
        .result (recon),
        .bad    (recon_bad)
    );

    // Shift the pixel windows on a data byte; clear them on a filter byte.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < MAX_PIXEL_BYTES; i++) begin
                left_reg[i] <= 8'd0;
                upl_reg[i]  <= 8'd0;
            end
        end else if (s1_fire) begin
            if (s1_data_reg) begin
                for (int i = MAX_PIXEL_BYTES - 1; i > 0; i--) begin
                    left_reg[i] <= left_reg[i-1];
                    upl_reg[i]  <= upl_reg[i-1];
                end
                left_reg[0] <= recon;
                upl_reg[0]  <= up_byte;
            end else begin
                for (int i = 0; i < MAX_PIXEL_BYTES; i++) begin
                    left_reg[i] <= 8'd0;
                    upl_reg[i]  <= 8'd0;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Output register
    // ---------------------------------------------------------------
    always_comb begin
        if (s1_fire && s1_data_reg) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_fire && s1_data_reg) begin
            m_pix_reg  <= recon;
            m_last_reg <= s1_last_reg;
            m_bad_reg  <= recon_bad;
        end
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = m_pix_reg;
    assign m_tlast    = m_last_reg;
    assign m_tuser[0] = m_bad_reg;

    // ---------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------
    `PSU_ASSERT(a_col_in_range, aclk, aresetn, LEN_W'(cc_reg) <= LEN_MAX)
    `PSU_ASSERT(a_stall_only_when_full, aclk, aresetn,
        !s_tready |-> (s1_valid_reg && s1_data_reg && m_valid_reg && !m_tready))
    `PSU_ASSERT(a_filter_byte_opens_row, aclk, aresetn,
        (s_fire && !is_data) |=> (cc_reg == CNT_W'(1)))
    `PSU_ASSERT(a_data_reaches_output, aclk, aresetn,
        (s1_fire && s1_data_reg) |=> m_valid_reg)

endmodule

>>> rtl/png_unf_line_store.sv
`timescale 1ns / 1ps

module png_unf_line_store
    import png_unf_pkg::*;
#(
    parameter int unsigned DEPTH  = 4096,
    parameter int unsigned ADDR_W = 12
) (
    input  logic              aclk,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [7:0]        rd_data,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [7:0]        wr_data
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Forward a same-edge write so a read never sees a stale byte.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            if (wr_en && (wr_addr == rd_addr)) begin
                rd_data_reg <= wr_data;
            end else begin
                rd_data_reg <= mem[rd_addr];
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/png_unf_predict.sv
`timescale 1ns / 1ps

module png_unf_predict
    import png_unf_pkg::*;
(
    input  pred_in_t   op,
    output logic [7:0] result,
    output logic       bad
);

    logic [8:0] sum_ab;
    logic [8:0] dbl_c;
    logic [8:0] pa;
    logic [8:0] pb;
    logic [8:0] pc;
    logic [7:0] pred;
    logic [7:0] paeth;

    // Paeth distances without a signed intermediate.
    assign sum_ab = {1'b0, op.left} + {1'b0, op.up};
    assign dbl_c  = {op.upleft, 1'b0};
    assign pa = (op.up >= op.upleft) ? {1'b0, op.up - op.upleft}
                                     : {1'b0, op.upleft - op.up};
    assign pb = (op.left >= op.upleft) ? {1'b0, op.left - op.upleft}
                                       : {1'b0, op.upleft - op.left};
    assign pc = (sum_ab >= dbl_c) ? (sum_ab - dbl_c) : (dbl_c - sum_ab);

    always_comb begin
        if ((pa <= pb) && (pa <= pc)) begin
            paeth = op.left;
        end else if (pb <= pc) begin
            paeth = op.up;
        end else begin
            paeth = op.upleft;
        end
    end

    always_comb begin
        bad = 1'b0;
        case (op.filt)
            FILT_NONE:  pred = 8'd0;
            FILT_SUB:   pred = op.left;
            FILT_UP:    pred = op.up;
            FILT_AVG:   pred = sum_ab[8:1];
            FILT_PAETH: pred = paeth;
            default: begin
                pred = 8'd0;
                bad  = 1'b1;
            end
        endcase
    end

    assign result = op.raw + pred;

endmodule

>>> tb/png_scanline_unfilter_tb.sv
`timescale 1ns / 1ps

module png_scanline_unfilter_tb;
    import png_unf_pkg::*;

    localparam int LINE_DEPTH  = 4096;
    localparam int PIX_DEPTH   = 8;
    // two pipeline stages plus margin; covers a filter byte still in flight
    localparam int PIPE_SLACK  = 6;
    localparam int HOLD_CYCLES = 400;
    localparam int STALL_LIMIT = 3000;

    // One reconstructed byte as it leaves the block.
    typedef struct packed {
        logic [7:0] pix;
        logic       eol;
        logic       bad;
    } pixel_t;

    // One row of the directed stimulus; typed marks a hand-computed result.
    typedef struct packed {
        logic [7:0] fb;
        logic       soi;
        logic       typed;
        logic [7:0] pix;
        logic       eol;
        logic       bad;
    } dir_row_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic                  cfg_index = CFG_BPP;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata   = '0;   // [7:0] filtered_byte
    logic [0:0]            s_tuser   = '0;   // [0] start_of_image
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [7:0]            m_tdata;          // [7:0] pixel_byte
    logic                  m_tlast;          // row_end
    logic [0:0]            m_tuser;          // [0] bad_filter

    // Shadow of the block state, advanced once per accepted input transfer.
    logic [7:0]  prev_line   [LINE_DEPTH];
    logic [7:0]  left_bytes  [PIX_DEPTH];
    logic [7:0]  above_bytes [PIX_DEPTH];
    int unsigned col_pos        = 0;
    int unsigned line_valid_len = 0;   // prefix of prev_line written so far
    filt_t       cur_filter     = FILT_NONE;
    logic        top_row        = 1'b1;
    logic [3:0]  reg_bpp        = BPP_RESET;
    logic [12:0] reg_bpr        = BPR_RESET;

    pixel_t   pending_pixels[$];
    dir_row_t steps[24];
    int       mismatch_count = 0;
    int       idle_cycles    = 0;
    bit       tx_calm        = 1'b0;
    bit       rx_calm        = 1'b0;
    bit       hold_req       = 1'b0;

    png_scanline_unfilter #(
        .MAX_ROW_BYTES   (LINE_DEPTH),
        .MAX_PIXEL_BYTES (PIX_DEPTH)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int gap_len();
        if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Paeth pick: the neighbor closest to left + up - upleft, ties in that order.
    function automatic logic [7:0] paeth_choice(logic [7:0] left_v, logic [7:0] up_v,
                                                logic [7:0] diag_v);
        int pa, pb, pc;
        pa = int'(up_v) - int'(diag_v);
        pb = int'(left_v) - int'(diag_v);
        pc = int'(left_v) + int'(up_v) - 2 * int'(diag_v);
        if (pa < 0) pa = -pa;
        if (pb < 0) pb = -pb;
        if (pc < 0) pc = -pc;
        if (pa <= pb && pa <= pc) return left_v;
        if (pb <= pc) return up_v;
        return diag_v;
    endfunction

    // Advance the shadow state by one input byte; report the pixel it yields.
    task automatic reconstruct_byte(input logic [7:0] fb, input logic soi,
                                    output logic produced, output pixel_t px);
        int unsigned bpp, len, x;
        logic [7:0]  a, b, c, r;
        logic        bad;
        bpp = (reg_bpp == 0) ? 1 : (reg_bpp > PIX_DEPTH) ? PIX_DEPTH : reg_bpp;
        len = (reg_bpr == 0) ? 1 : (reg_bpr > LINE_DEPTH) ? LINE_DEPTH : reg_bpr;
        produced = 1'b0;
        px       = '0;
        // start of image restarts the row count and blanks the row above
        if (soi) begin
            col_pos = 0;
            top_row = 1'b1;
        end
        if (col_pos == 0) begin
            // filter byte: latch the type, clear the windows for the left edge
            cur_filter  = (fb > 8'd4) ? FILT_BAD : filt_t'(fb[2:0]);
            left_bytes  = '{default: 8'h00};
            above_bytes = '{default: 8'h00};
            col_pos     = 1;
        end else begin
            x = col_pos - 1;
            if (x >= LINE_DEPTH) x = LINE_DEPTH - 1;
            a   = left_bytes[bpp-1];
            c   = above_bytes[bpp-1];
            b   = top_row ? 8'h00 : prev_line[x];
            bad = 1'b0;
            case (cur_filter)
                FILT_NONE:  r = fb;
                FILT_SUB:   r = fb + a;
                FILT_UP:    r = fb + b;
                FILT_AVG:   r = fb + 8'((9'(a) + 9'(b)) >> 1);
                FILT_PAETH: r = fb + paeth_choice(a, b, c);
                default: begin
                    r   = fb;
                    bad = 1'b1;
                end
            endcase
            for (int i = PIX_DEPTH - 1; i > 0; i--) begin
                left_bytes[i]  = left_bytes[i-1];
                above_bytes[i] = above_bytes[i-1];
            end
            left_bytes[0]  = r;
            above_bytes[0] = b;
            prev_line[x]   = r;
            if (x + 1 > line_valid_len) line_valid_len = x + 1;
            px.pix = r;
            px.eol = (x + 1 >= len);
            px.bad = bad;
            if (px.eol) begin
                col_pos = 0;
                top_row = 1'b0;
            end else begin
                col_pos = x + 2;
            end
            produced = 1'b1;
        end
    endtask

    // Offer one byte, hold it until the transfer, then log what it should yield.
    task automatic push_byte(input logic [7:0] fb, input logic soi,
                             input logic typed, input pixel_t typed_px);
        logic   produced;
        pixel_t px;
        if (!tx_calm && $urandom_range(0, 99) < 20) begin
            s_tvalid <= 1'b0;
            repeat (gap_len()) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= fb;
        s_tuser  <= soi;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        reconstruct_byte(fb, soi, produced, px);
        if (produced) pending_pixels.push_back(typed ? typed_px : px);
    endtask

    // Write both geometry registers back to back; valid stays up between them.
    task automatic load_geometry(input logic [12:0] bpp_word, input logic [12:0] bpr_word);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_BPP;
        cfg_data  <= bpp_word;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        reg_bpp   = bpp_word[3:0];
        cfg_index <= CFG_BPR;
        cfg_data  <= bpr_word;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        reg_bpr   = bpr_word;
        cfg_valid <= 1'b0;
    endtask

    // Drop valid, wait for every pixel, then let a trailing filter byte land.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge aclk);
        repeat (PIPE_SLACK) @(posedge aclk);
    endtask

    // Well-formed rows with random content; noise adds image restarts anywhere.
    task automatic send_stream(input int count, input bit noise);
        logic [7:0] fb;
        logic       soi;
        int         pick;
        for (int k = 0; k < count; k++) begin
            soi = 1'b0;
            if (col_pos == 0) begin
                if ($urandom_range(0, 99) < 80) fb = 8'($urandom_range(0, 4));
                else fb = 8'($urandom_range(5, 255));
                soi = noise && ($urandom_range(0, 99) < 6);
            end else begin
                pick = $urandom_range(0, 9);
                fb   = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF : 8'($urandom_range(0, 255));
                soi  = noise && ($urandom_range(0, 99) < 2);
            end
            // never read a line-store entry that no earlier row has written
            if (!soi && col_pos != 0 && !top_row && col_pos - 1 >= line_valid_len)
                soi = 1'b1;
            push_byte(fb, soi, 1'b0, '0);
        end
    endtask

    task automatic run_phase(input logic [12:0] bpp_word, input logic [12:0] bpr_word,
                             input int count, input bit noise, input bit calm_tx,
                             input bit calm_rx, input bit hold);
        tx_calm = calm_tx;
        rx_calm = calm_rx;
        if (hold) hold_req = 1'b1;
        load_geometry(bpp_word, bpr_word);
        send_stream(count, noise);
        settle();
    endtask

    // Output side: random back-pressure, plus one long hold on request.
    initial begin
        int stall_left;
        stall_left = 0;
        wait (aresetn === 1'b1);
        forever begin
            @(posedge aclk);
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (hold_req) begin
                hold_req   = 1'b0;
                stall_left = HOLD_CYCLES - 1;
                m_tready   <= 1'b0;
            end else if (!rx_calm && $urandom_range(0, 99) < 15) begin
                stall_left = gap_len() - 1;
                m_tready   <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Compare every output transfer with the oldest pending pixel.
    always @(posedge aclk) begin : check_pixels
        pixel_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_pixels.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected pixel, actual pix=%h eol=%b bad=%b",
                         $time, m_tdata, m_tlast, m_tuser[0]);
            end else begin
                want = pending_pixels.pop_front();
                if (m_tdata !== want.pix || m_tlast !== want.eol || m_tuser[0] !== want.bad) begin
                    mismatch_count++;
                    $display("%0t: pixel mismatch, expected pix=%h eol=%b bad=%b, actual pix=%h eol=%b bad=%b",
                             $time, want.pix, want.eol, want.bad, m_tdata, m_tlast, m_tuser[0]);
                end
            end
        end
    end

    // Watchdog: abort when no channel moves a transfer for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("png_scanline_unfilter verification failed");
            $finish;
        end
    end

    initial begin
        // Three-byte rows at one byte per pixel; the row above is listed in the
        // comments so the typed results can be checked by hand.
        steps = '{
            '{8'h00, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},  // image start, None
            '{8'h00, 1'b0, 1'b1, 8'h00, 1'b0, 1'b0},
            '{8'hFF, 1'b0, 1'b1, 8'hFF, 1'b0, 1'b0},
            '{8'h80, 1'b0, 1'b1, 8'h80, 1'b1, 1'b0},
            '{8'h01, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},  // Sub, left edge reads zero
            '{8'hFF, 1'b0, 1'b1, 8'hFF, 1'b0, 1'b0},
            '{8'h01, 1'b0, 1'b1, 8'h00, 1'b0, 1'b0},  // wraps
            '{8'h10, 1'b0, 1'b1, 8'h10, 1'b1, 1'b0},
            '{8'h02, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},  // Up over FF 00 10
            '{8'h01, 1'b0, 1'b1, 8'h00, 1'b0, 1'b0},
            '{8'h05, 1'b0, 1'b1, 8'h05, 1'b0, 1'b0},
            '{8'hF0, 1'b0, 1'b1, 8'h00, 1'b1, 1'b0},
            '{8'h03, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},  // Average over 00 05 00
            '{8'h80, 1'b0, 1'b1, 8'h80, 1'b0, 1'b0},
            '{8'h01, 1'b0, 1'b1, 8'h43, 1'b0, 1'b0},
            '{8'h00, 1'b0, 1'b1, 8'h21, 1'b1, 1'b0},
            '{8'h04, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},  // Paeth, left to the predictor
            '{8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
            '{8'h7F, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
            '{8'hFF, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
            '{8'hFF, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},  // unknown type, widest
            '{8'h5A, 1'b0, 1'b1, 8'h5A, 1'b0, 1'b1},
            '{8'h05, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},  // restart mid-row, smallest bad
            '{8'h12, 1'b0, 1'b1, 8'h12, 1'b0, 1'b1}
        };

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed pass: every filter type, wraparound, bad types, mid-row restart.
        load_geometry(13'd1, 13'd3);
        for (int k = 0; k < $size(steps); k++)
            push_byte(steps[k].fb, steps[k].soi, steps[k].typed,
                      '{steps[k].pix, steps[k].eol, steps[k].bad});
        settle();

        // Zero registers act as one.
        run_phase(13'd0, 13'd0, 60, 1'b1, 1'b0, 1'b0, 1'b0);
        run_phase(13'd1, 13'd1, 60, 1'b1, 1'b1, 1'b1, 1'b0);
        run_phase(13'd8, 13'd16, 150, 1'b1, 1'b0, 1'b0, 1'b0);
        // All ones: pixel width saturates at eight bytes.
        run_phase(13'h1FFF, 13'd5, 100, 1'b1, 1'b0, 1'b1, 1'b0);
        // Long output hold with a steady sender to back the block up.
        run_phase(13'd3, 13'd12, 150, 1'b1, 1'b1, 1'b0, 1'b1);
        // Oversized row length: the clamp holds it at LINE_DEPTH, and the phase sends less than one row.
        run_phase(13'd4, 13'h1FFF, 100, 1'b0, 1'b0, 1'b0, 1'b0);
        run_phase(13'd2, 13'd4096, 60, 1'b1, 1'b0, 1'b0, 1'b0);
        for (int k = 0; k < 7; k++)
            run_phase(13'($urandom_range(0, 8191)),
                      ($urandom_range(0, 9) == 0) ? 13'd0 : 13'($urandom_range(1, 40)),
                      150, 1'b1, k[0], (k % 3) == 0, 1'b0);

        mismatch_count += pending_pixels.size();
        if (mismatch_count == 0)
            $display("png_scanline_unfilter verification clean");
        else
            $display("png_scanline_unfilter verification failed");
        $finish;
    end

endmodule
